FILE: hdl/lccn_pkg.sv
// Shared constants and types for the Luhn card number classifier.
package lccn_pkg;

    localparam int CARD_W      = 64;
    localparam int BIN_W       = CARD_W - 1;
    localparam int DIGIT_W     = 4;
    localparam int BCD_DIGITS  = 19;
    localparam int BCD_W       = BCD_DIGITS * DIGIT_W;
    localparam int MAX_DIGITS  = 19;
    localparam int SHIFT_CNT_W = $clog2(BIN_W);
    localparam int IDX_W       = $clog2(BCD_DIGITS + 1);

    localparam int LEN_SHORT = 13;
    localparam int LEN_MID   = 15;
    localparam int LEN_LONG  = 16;

    localparam logic [DIGIT_W-1:0] DIG_ONE   = 4'd1;
    localparam logic [DIGIT_W-1:0] DIG_THREE = 4'd3;
    localparam logic [DIGIT_W-1:0] DIG_FOUR  = 4'd4;
    localparam logic [DIGIT_W-1:0] DIG_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIG_SEVEN = 4'd7;
    localparam logic [DIGIT_W-1:0] DIG_NINE  = 4'd9;
    localparam logic [DIGIT_W:0]   DIG_TEN   = 5'd10;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_LEN15   = 2'd1,
        KIND_LEN16   = 2'd2,
        KIND_LEAD4   = 2'd3
    } card_kind_t;

    typedef struct packed {
        logic       done;
        card_kind_t kind;
    } scan_status_t;

endpackage

FILE: hdl/lccn_ifs.sv
// Request channels of the card number classifier.
interface lccn_card_if;
    logic                                valid;
    logic                                ready;
    logic signed [lccn_pkg::CARD_W-1:0]  card_number;
    modport source(output valid, output card_number, input ready);
    modport sink(input valid, input card_number, output ready);
endinterface

interface lccn_kind_if;
    logic       valid;
    logic       ready;
    logic [1:0] card_kind;
    modport source(output valid, output card_kind, input ready);
    modport sink(input valid, input card_kind, output ready);
endinterface

FILE: hdl/lccn_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3).
module lccn_bcd_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lccn_pkg::BIN_W-1:0]   value,
    output logic                         busy,
    output logic                         done,
    output logic [lccn_pkg::BCD_W-1:0]   bcd
);

    logic [lccn_pkg::BIN_W-1:0]       bin_reg, bin_next;
    logic [lccn_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [lccn_pkg::BCD_W-1:0]       adj;
    logic [lccn_pkg::SHIFT_CNT_W-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    always_comb
    begin
        for (int k = 0; k < lccn_pkg::BCD_DIGITS; k++)
        begin
            if (bcd_reg[k*lccn_pkg::DIGIT_W +: lccn_pkg::DIGIT_W] >= lccn_pkg::DIG_FIVE)
                adj[k*lccn_pkg::DIGIT_W +: lccn_pkg::DIGIT_W] =
                    bcd_reg[k*lccn_pkg::DIGIT_W +: lccn_pkg::DIGIT_W] + lccn_pkg::DIG_THREE;
            else
                adj[k*lccn_pkg::DIGIT_W +: lccn_pkg::DIGIT_W] =
                    bcd_reg[k*lccn_pkg::DIGIT_W +: lccn_pkg::DIGIT_W];
        end
        bcd_next = {adj[lccn_pkg::BCD_W-2:0], bin_reg[lccn_pkg::BIN_W-1]};
        bin_next = {bin_reg[lccn_pkg::BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg &&
                        cnt_reg == lccn_pkg::SHIFT_CNT_W'(lccn_pkg::BIN_W - 1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lccn_pkg::SHIFT_CNT_W'(lccn_pkg::BIN_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("conversion done without a preceding busy cycle");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) && !start |-> done_reg)
        else $error("conversion stopped without done");

endmodule

FILE: hdl/lccn_luhn_scan.sv
// Digit-serial Luhn checksum, digit count and issuer classification.
module lccn_luhn_scan #(
    parameter int MAX_DIGITS = lccn_pkg::MAX_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         neg,
    input  logic [lccn_pkg::BCD_W-1:0]   bcd,
    output lccn_pkg::scan_status_t       status
);

    logic [lccn_pkg::BCD_W-1:0]   dig_reg;
    logic [lccn_pkg::IDX_W-1:0]   idx_reg;
    logic [lccn_pkg::IDX_W-1:0]   count_reg;
    logic [lccn_pkg::DIGIT_W-1:0] sum_reg, top_reg, next_reg, prev_reg;
    logic                         neg_reg;
    logic                         busy_reg;
    logic                         fin_reg;
    logic                         done_reg;
    lccn_pkg::card_kind_t         kind_reg;

    logic [lccn_pkg::DIGIT_W-1:0] d;
    logic [lccn_pkg::DIGIT_W:0]   dbl;
    logic [lccn_pkg::DIGIT_W-1:0] dd;
    logic [lccn_pkg::DIGIT_W:0]   acc;
    logic [lccn_pkg::DIGIT_W-1:0] sum_next;

    function automatic lccn_pkg::card_kind_t classify(
        input logic [lccn_pkg::IDX_W-1:0]   count,
        input logic [lccn_pkg::DIGIT_W-1:0] top,
        input logic [lccn_pkg::DIGIT_W-1:0] nxt
    );
        lccn_pkg::card_kind_t k;
        k = lccn_pkg::KIND_INVALID;
        if (count == lccn_pkg::IDX_W'(lccn_pkg::LEN_MID))
        begin
            if (top == lccn_pkg::DIG_THREE &&
                (nxt == lccn_pkg::DIG_FOUR || nxt == lccn_pkg::DIG_SEVEN))
                k = lccn_pkg::KIND_LEN15;
        end
        else if (count == lccn_pkg::IDX_W'(lccn_pkg::LEN_LONG))
        begin
            if (top == lccn_pkg::DIG_FIVE)
            begin
                if (nxt >= lccn_pkg::DIG_ONE && nxt <= lccn_pkg::DIG_FIVE)
                    k = lccn_pkg::KIND_LEN16;
            end
            else if (top == lccn_pkg::DIG_FOUR)
                k = lccn_pkg::KIND_LEAD4;
        end
        else if (count == lccn_pkg::IDX_W'(lccn_pkg::LEN_SHORT))
        begin
            if (top == lccn_pkg::DIG_FOUR)
                k = lccn_pkg::KIND_LEAD4;
        end
        return k;
    endfunction

    always_comb
    begin
        d   = dig_reg[lccn_pkg::DIGIT_W-1:0];
        dbl = {d, 1'b0};
        if (!idx_reg[0])
            dd = d;
        else if (dbl >= lccn_pkg::DIG_TEN)
            dd = lccn_pkg::DIGIT_W'(dbl - {1'b0, lccn_pkg::DIG_NINE});
        else
            dd = dbl[lccn_pkg::DIGIT_W-1:0];
        acc = {1'b0, sum_reg} + {1'b0, dd};
        if (acc >= lccn_pkg::DIG_TEN)
            sum_next = lccn_pkg::DIGIT_W'(acc - lccn_pkg::DIG_TEN);
        else
            sum_next = acc[lccn_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            fin_reg  <= !start && busy_reg &&
                        idx_reg == lccn_pkg::IDX_W'(lccn_pkg::BCD_DIGITS - 1);
            done_reg <= !start && !busy_reg && fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == lccn_pkg::IDX_W'(lccn_pkg::BCD_DIGITS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dig_reg   <= bcd;
            neg_reg   <= neg;
            sum_reg   <= '0;
            count_reg <= '0;
            top_reg   <= '0;
            next_reg  <= '0;
            prev_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dig_reg  <= {{lccn_pkg::DIGIT_W{1'b0}}, dig_reg[lccn_pkg::BCD_W-1:lccn_pkg::DIGIT_W]};
            sum_reg  <= sum_next;
            prev_reg <= d;
            if (d != '0)
            begin
                count_reg <= idx_reg + 1'b1;
                top_reg   <= d;
                next_reg  <= prev_reg;
            end
        end
        if (fin_reg)
        begin
            if (neg_reg || sum_reg != '0 ||
                count_reg > lccn_pkg::IDX_W'(MAX_DIGITS))
                kind_reg <= lccn_pkg::KIND_INVALID;
            else
                kind_reg <= classify(count_reg, top_reg, next_reg);
        end
    end

    assign status.done = done_reg;
    assign status.kind = kind_reg;

    a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !busy_reg ##1 done_reg)
        else $error("scan finish not followed by done");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg < lccn_pkg::IDX_W'(lccn_pkg::BCD_DIGITS))
        else $error("digit index beyond the digit store");

endmodule

FILE: hdl/luhn_card_number_classifier_unit.sv
// Top level of the Luhn mod-10 card number classifier.
// Usage:
//   card   : request channel carrying one signed 64-bit card_number.
//   result : request channel carrying one 2-bit card_kind per card
//            (0 invalid, 1 fifteen digits 34/37, 2 sixteen digits 51-55,
//            3 thirteen or sixteen digits leading 4).
//   Zero and negative numbers classify as invalid.
// Timing:
//   The number is turned into 19 BCD digits one bit per cycle, the digits
//   are scanned one per cycle, and the scanner classifies the card and
//   hands the kind to the output register, where the result is offered.
//   One card is in work at a time: the next card is taken once the result
//   leaves the scanner. The bit-serial BCD converter is the slowest part.
// Reset:
//   rst_n clears all control state; no request is pending afterward.
// Stall:
//   The result sits in an output register until taken; the next card is
//   accepted meanwhile, and a finished result waits in the scanner while
//   the output register is still full.
module luhn_card_number_classifier_unit #(
    parameter int MAX_DIGITS = lccn_pkg::MAX_DIGITS
) (
    input  logic          clk,
    input  logic          rst_n,
    lccn_card_if.sink     card,
    lccn_kind_if.source   result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t                       state_reg;
    logic                         neg_reg;
    logic                         out_valid_reg;
    lccn_pkg::card_kind_t         out_kind_reg;

    logic                         card_acc;
    logic                         conv_busy;
    logic                         conv_done;
    logic [lccn_pkg::BCD_W-1:0]   bcd;
    lccn_pkg::scan_status_t       scan_status;
    logic                         out_free;

    assign card.ready = (state_reg == ST_IDLE);
    assign card_acc   = card.valid && card.ready;
    assign out_free   = !out_valid_reg || result.ready;

    lccn_bcd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (card_acc),
        .value (card.card_number[lccn_pkg::BIN_W-1:0]),
        .busy  (conv_busy),
        .done  (conv_done),
        .bcd   (bcd)
    );

    lccn_luhn_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_done),
        .neg    (neg_reg),
        .bcd    (bcd),
        .status (scan_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            out_kind_reg  <= lccn_pkg::KIND_INVALID;
        end
        else
        begin
            if (state_reg == ST_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= scan_status.kind;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (card_acc)
                    begin
                        neg_reg   <= card.card_number[lccn_pkg::CARD_W-1];
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    if (conv_done)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (scan_status.done)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.card_kind = out_kind_reg;

    a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result loaded outside the hold state");

    a_conv_only_when_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_busy |-> state_reg == ST_CONV)
        else $error("converter running outside the conversion state");

endmodule
